FILE: rtl/core/evp_pkg.sv
// Package: shared types and constants for the header parser core.
`default_nettype none
package evp_pkg;
	localparam logic [15:0] MIN_LINK_BYTES = 16'd14;
	localparam logic [15:0] ETH_IPV4  = 16'h0800;
	localparam logic [15:0] PPP_IPV4  = 16'h0021;
	localparam logic [15:0] ETH_VLAN  = 16'h8100;
	localparam logic [15:0] ETH_QINQ  = 16'h9100;
	localparam logic [15:0] ETH_PPPOE = 16'h8864;
	localparam logic [7:0]  PROTO_TCP = 8'h06;
	localparam logic [7:0]  PROTO_UDP = 8'h11;
	localparam logic [1:0]  ST_L4    = 2'd0;
	localparam logic [1:0]  ST_OTHER = 2'd1;
	localparam logic [1:0]  ST_BAD   = 2'd2;
	localparam int QDEPTH = 2;

	// Frame summary handed from the front to the back part.
	typedef struct packed {
		logic        ok;
		logic [15:0] cap;
		logic [15:0] l3;
		logic [5:0]  ihl;
		logic [15:0] tot;
		logic [7:0]  proto;
		logic        tseen;
		logic [11:0] tid;
		logic [15:0] sess;
		logic [31:0] sa;
		logic [31:0] da;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [5:0]  l4;
	} frame_sum_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        vlan_seen;
		logic [11:0] vlan_ident;
		logic [15:0] pppoe_session;
		logic [7:0]  ip_protocol;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [15:0] src_port;
		logic [15:0] destination_port;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} result_t;
endpackage
`default_nettype wire

FILE: rtl/core/evp_front.sv
// Front part: walks the header chain one byte per in_valid cycle, emits a frame summary.
`default_nettype none
module evp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [7:0]       in_byte,
	input  wire logic             in_last,
	output evp_pkg::frame_sum_t   sum,
	output logic                  sum_valid
);
	import evp_pkg::*;
	typedef enum logic [2:0] {PH_LINK, PH_TAG, PH_PPPOE, PH_IP, PH_DONE} phase_t;

	phase_t      ph_q;
	logic [15:0] cnt_q, nhs_q, type_q, l3_q, tot_q, sess_q, sp_q, dp_q;
	logic        fail_q, tseen_q;
	logic [11:0] tid_q;
	logic [5:0]  ihl_q, l4_q;
	logic [7:0]  proto_q;
	logic [31:0] sa_q, da_q;

	logic [15:0] o, oi, q, ntype;
	logic        live;
	phase_t      ph_n;
	logic        fail_n;
	logic [15:0] l3_n, nhs_n;

	assign live = cnt_q != 16'hffff;
	assign o = cnt_q - nhs_q;
	assign oi = cnt_q - l3_q;
	assign q = oi - {10'd0, ihl_q};
	assign ntype = {type_q[15:8], in_byte};

	always_comb begin
		ph_n = ph_q; fail_n = fail_q; l3_n = l3_q; nhs_n = nhs_q;
		if (live && ((ph_q == PH_LINK && cnt_q == 16'd13) ||
			((ph_q == PH_TAG || ph_q == PH_PPPOE) &&
			o == ((ph_q == PH_TAG) ? 16'd3 : 16'd7)))) begin
			nhs_n = cnt_q + 16'd1;
			if (ntype == ETH_IPV4 || ntype == PPP_IPV4) begin
				ph_n = PH_IP; l3_n = cnt_q + 16'd1;
			end else if (ntype == ETH_VLAN || ntype == ETH_QINQ) begin
				ph_n = PH_TAG;
			end else if (ntype == ETH_PPPOE) begin
				ph_n = PH_PPPOE;
			end else begin
				ph_n = PH_DONE; fail_n = 1'b1;
			end
		end
		if (live && ph_q == PH_IP && oi == 16'd0 && in_byte[3:0] < 4'd5) begin
			ph_n = PH_DONE; fail_n = 1'b1;
		end
	end

	// Summary of the frame that ends with this byte.
	always_comb begin
		sum.cap   = live ? cnt_q + 16'd1 : cnt_q;
		sum.l3    = l3_n;
		sum.ok    = !fail_n && ph_n == PH_IP;
		sum.ihl   = ihl_q;  sum.tot = tot_q; sum.proto = proto_q;
		sum.tseen = tseen_q; sum.tid = tid_q; sum.sess = sess_q;
		sum.sa = sa_q; sum.da = da_q; sum.sp = sp_q; sum.dp = dp_q; sum.l4 = l4_q;
		if (live) begin
			case (ph_q)
				PH_TAG: begin
					if (o == 16'd0) sum.tid = {in_byte[3:0], 8'd0};
					else if (o == 16'd1) begin
						sum.tid = {tid_q[11:8], in_byte}; sum.tseen = 1'b1;
					end
				end
				PH_PPPOE: begin
					if (o == 16'd2) sum.sess = {in_byte, 8'd0};
					else if (o == 16'd3) sum.sess = {sess_q[15:8], in_byte};
				end
				PH_IP: begin
					if (oi == 16'd0) sum.ihl = {in_byte[3:0], 2'b00};
					else if (oi < {10'd0, ihl_q}) begin
						if (oi == 16'd2) sum.tot = {in_byte, 8'd0};
						else if (oi == 16'd3) sum.tot = {tot_q[15:8], in_byte};
						else if (oi == 16'd9) sum.proto = in_byte;
						else if (oi >= 16'd12 && oi < 16'd16) sum.sa = {sa_q[23:0], in_byte};
						else if (oi >= 16'd16 && oi < 16'd20) sum.da = {da_q[23:0], in_byte};
					end else begin
						if (q == 16'd0) sum.sp = {in_byte, 8'd0};
						else if (q == 16'd1) sum.sp = {sp_q[15:8], in_byte};
						else if (q == 16'd2) sum.dp = {in_byte, 8'd0};
						else if (q == 16'd3) sum.dp = {dp_q[15:8], in_byte};
						else if (q == 16'd12) sum.l4 = {in_byte[7:4], 2'b00};
					end
				end
				default: ;
			endcase
		end
	end

	assign sum_valid = in_valid && in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_LINK; cnt_q <= '0; nhs_q <= 16'd14; type_q <= '0; fail_q <= 1'b0;
			tid_q <= '0; tseen_q <= 1'b0; sess_q <= '0; l3_q <= '0; ihl_q <= '0;
			tot_q <= '0; proto_q <= '0; sa_q <= '0; da_q <= '0; sp_q <= '0; dp_q <= '0;
			l4_q <= '0;
		end else if (in_valid) begin
			if (in_last) begin
				ph_q <= PH_LINK; cnt_q <= '0; nhs_q <= 16'd14; type_q <= '0; fail_q <= 1'b0;
				tid_q <= '0; tseen_q <= 1'b0; sess_q <= '0; l3_q <= '0; ihl_q <= '0;
				tot_q <= '0; proto_q <= '0; sa_q <= '0; da_q <= '0; sp_q <= '0;
				dp_q <= '0; l4_q <= '0;
			end else begin
				if (live) begin
					cnt_q <= cnt_q + 16'd1;
					if ((ph_q == PH_LINK && cnt_q == 16'd12) ||
						(ph_q == PH_TAG && o == 16'd2) || (ph_q == PH_PPPOE && o == 16'd6))
						type_q <= {in_byte, 8'd0};
					else if ((ph_q == PH_LINK && cnt_q == 16'd13) ||
						(ph_q == PH_TAG && o == 16'd3) || (ph_q == PH_PPPOE && o == 16'd7))
						type_q <= ntype;
				end
				ph_q <= ph_n; fail_q <= fail_n; l3_q <= l3_n; nhs_q <= nhs_n;
				ihl_q <= sum.ihl; tot_q <= sum.tot; proto_q <= sum.proto;
				tseen_q <= sum.tseen; tid_q <= sum.tid; sess_q <= sum.sess;
				sa_q <= sum.sa; da_q <= sum.da; sp_q <= sum.sp; dp_q <= sum.dp;
				l4_q <= sum.l4;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/evp_queue.sv
// Two-entry queue of frame summaries between front and back.
`default_nettype none
module evp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  evp_pkg::frame_sum_t wdata,
	output logic                full,
	input  wire logic           rd,
	output evp_pkg::frame_sum_t rdata,
	output logic                nempty
);
	import evp_pkg::*;
	frame_sum_t  mem_q [QDEPTH];
	logic        wp_q, rp_q;
	logic [1:0]  n_q;

	assign full = n_q == 2'(QDEPTH);
	assign nempty = n_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; n_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			n_q <= n_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/evp_back.sv
// Back part: two-stage length checks and result formatting with output register.
`default_nettype none
module evp_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  evp_pkg::frame_sum_t sum,
	input  wire logic           sum_valid,
	output logic                sum_take,
	output evp_pkg::result_t    res,
	output logic                res_valid,
	input  wire logic           res_ready
);
	import evp_pkg::*;
	// stage 1: precomputed sums
	logic        v_s1;
	frame_sum_t  f_s1;
	logic [16:0] hdr_s1, pay_s1, l4t_s1, avail_s1;
	logic [5:0]  l4len_s1;
	logic        l4p_s1;
	logic        s1_free, out_free;
	logic [5:0]  l4c;
	logic [16:0] h;
	logic        base, ok_l4;
	result_t     res_n;

	assign out_free = !res_valid || res_ready;
	assign s1_free = !v_s1 || out_free;
	assign sum_take = sum_valid && s1_free;
	assign h = {1'b0, sum.l3} + {11'd0, sum.ihl};
	assign l4c = (sum.proto == PROTO_TCP) ? sum.l4 : 6'd8;

	always_ff @(posedge clk) begin
		if (sum_take) begin
			f_s1 <= sum;
			hdr_s1 <= h;
			l4len_s1 <= l4c;
			l4t_s1 <= h + {11'd0, l4c};
			pay_s1 <= {1'b0, sum.tot} - {11'd0, sum.ihl};
			avail_s1 <= {1'b0, sum.cap} - {1'b0, sum.l3};
			l4p_s1 <= sum.proto == PROTO_TCP || sum.proto == PROTO_UDP;
		end
	end

	always_comb begin
		base = f_s1.ok && f_s1.cap >= MIN_LINK_BYTES && f_s1.cap > f_s1.l3 &&
			f_s1.ihl >= 6'd20 && {1'b0, f_s1.cap} >= hdr_s1 &&
			{1'b0, f_s1.tot} <= avail_s1 && f_s1.tot >= {10'd0, f_s1.ihl};
		ok_l4 = {1'b0, f_s1.cap} >= hdr_s1 + 17'd4 &&
			!(f_s1.proto == PROTO_TCP &&
			({1'b0, f_s1.cap} < hdr_s1 + 17'd13 || l4len_s1 < 6'd20)) &&
			{11'd0, l4len_s1} <= pay_s1 && {1'b0, f_s1.cap} >= l4t_s1;
		res_n = '0;
		res_n.status = ST_BAD;
		if (base && (!l4p_s1 || ok_l4)) begin
			res_n.status = l4p_s1 ? ST_L4 : ST_OTHER;
			res_n.vlan_seen = f_s1.tseen;
			res_n.vlan_ident = f_s1.tid;
			res_n.pppoe_session = f_s1.sess;
			res_n.ip_protocol = f_s1.proto;
			res_n.source_address = f_s1.sa;
			res_n.destination_address = f_s1.da;
			if (l4p_s1) begin
				res_n.src_port = f_s1.sp;
				res_n.destination_port = f_s1.dp;
				res_n.payload_offset = l4t_s1[15:0];
				res_n.payload_length = pay_s1[15:0] - {10'd0, l4len_s1};
			end else begin
				res_n.payload_offset = hdr_s1[15:0];
				res_n.payload_length = pay_s1[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; res_valid <= 1'b0; res <= '0;
		end else begin
			if (s1_free) v_s1 <= sum_take;
			if (out_free) begin
				res_valid <= v_s1;
				if (v_s1) res <= res_n;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/eth_vlan_pppoe_ipv4_l4_header_parser_core.sv
// Top level: Ethernet/VLAN/PPPoE/IPv4/L4 header parser core.
// Throughput: one frame byte per cycle when s_tready is high; no bubbles between frames.
// Result path: after the last byte is accepted, its summary is written into the queue,
//   then registered in stage 1 and then in the output register.
// The two-entry summary queue absorbs output stalls; s_tready drops only when it is full.
// Reset: arst_n asynchronous active low clears all parse and handshake state.
`default_nettype none
module eth_vlan_pppoe_ipv4_l4_header_parser_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] frame_byte
	input  wire logic         s_tlast,   // frame_end
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [167:0]      m_tdata,   // vlan_seen, vlan_ident, pppoe_session,
	                                     // ip_protocol, source_address,
	                                     // destination_address, src_port,
	                                     // destination_port, payload_offset,
	                                     // payload_length, then zero pad
	output logic [1:0]        m_tuser    // parse_status
);
	import evp_pkg::*;
	frame_sum_t sum, qd;
	logic       sv, qfull, qne, take;
	result_t    r;

	// Front runs whenever the queue has room for a possible summary.
	assign s_tready = !qfull;

	evp_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid && s_tready), .in_byte(s_tdata),
		.in_last(s_tlast), .sum, .sum_valid(sv)
	);

	evp_queue u_queue (
		.clk, .arst_n, .wr(sv), .wdata(sum), .full(qfull),
		.rd(take), .rdata(qd), .nempty(qne)
	);

	evp_back u_back (
		.clk, .arst_n, .sum(qd), .sum_valid(qne), .sum_take(take),
		.res(r), .res_valid(m_tvalid), .res_ready(m_tready)
	);

	assign m_tuser = r.status;
	assign m_tdata = {3'd0, r.payload_length, r.payload_offset, r.destination_port,
		r.src_port, r.destination_address, r.source_address, r.ip_protocol,
		r.pppoe_session, r.vlan_ident, r.vlan_seen};
endmodule
`default_nettype wire
